// ----- rtl/mersenne_twister_word_generator_assert.svh -----
// ----------------------------------------------------------------------------
// mt word generator assertion macros
// concurrent assertion forms for the generator datapath
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_WORD_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_WORD_GENERATOR_ASSERT_SVH

// consequent checked in the same cycle
`define MTWG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MTWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mtwg_pkg.sv -----
// ----------------------------------------------------------------------------
// mt word generator package
// sizes, constants and controller/datapath signal groups
// ----------------------------------------------------------------------------
package mtwg_pkg;

  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ADDR_W        = $clog2(STATE_WORDS + 1);

  typedef logic [ADDR_W-1:0] idx_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam idx_t LAST_IDX = idx_t'(STATE_WORDS - 1);
  localparam idx_t FULL_IDX = idx_t'(STATE_WORDS);
  localparam idx_t WRAP_IDX = idx_t'(STATE_WORDS - MIDDLE_OFFSET);
  localparam idx_t MID_OFS  = idx_t'(MIDDLE_OFFSET);

  localparam word_t TWIST_MATRIX  = 32'h9908_b0df;
  localparam word_t UPPER_MASK    = 32'h8000_0000;
  localparam word_t LOWER_MASK    = 32'h7fff_ffff;
  localparam word_t TEMPER_MASK_B = 32'h9d2c_5680;
  localparam word_t TEMPER_MASK_C = 32'hefc6_0000;
  localparam word_t SEED_MULT     = 32'd1812433253;
  localparam word_t SEED_RESET    = 32'd5489;

  // commands from the controller, at most one set per cycle
  typedef struct packed {
    logic seed_start;
    logic seed_write;
    logic seed_step;
    logic tw_start;
    logic tw_load;
    logic tw_read;
    logic tw_write;
    logic draw_read;
    logic draw_out;
  } cmd_t;

  typedef struct packed {
    logic seeded;
    logic pos_full;
    logic k_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/mtwg_channels.sv -----
// ----------------------------------------------------------------------------
// mt word generator channels
// request and response valid/ready interfaces
// ----------------------------------------------------------------------------
interface mtwg_req_if;
  logic valid;
  logic ready;
  logic reseed_first;

  modport source (output valid, output reseed_first, input ready);
  modport sink   (input valid, input reseed_first, output ready);
endinterface

interface mtwg_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [mtwg_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ----- rtl/mersenne_twister_word_generator.sv -----
// ----------------------------------------------------------------------------
// mersenne twister word generator
// mt19937 32-bit generator: one tempered word per request
// ----------------------------------------------------------------------------
//  channel    dir  payload             transfer
//  req_i      in   reseed_first        valid && ready
//  rsp_o      out  random_word[31:0]   valid && ready
//  seed cfg   in   seed_value_i[31:0]  seed_we_i
//
// a draw from a prepared store reads the store when the request is taken,
// then tempers the registered read into the output register once it is free
// the draw after each 624 draws twists first, one word per read and write state
// seeding (first request after reset, or reseed_first) runs one multiply and
// one add per store word, and always twists
// reset takes no pass over the store; the seed register resets to 5489
// a request is taken while an earlier word still waits in the output register
module mersenne_twister_word_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        seed_we_i,
  input  logic [mtwg_pkg::WORD_W-1:0] seed_value_i,
  mtwg_req_if.sink                    req_i,
  mtwg_rsp_if.source                  rsp_o
);

  mtwg_pkg::cmd_t    cmd;
  mtwg_pkg::status_t status;
  logic              req_ready;
  logic              out_valid;
  mtwg_pkg::word_t   out_word;

  mtwg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_reseed_i (req_i.reseed_first),
    .req_ready_o  (req_ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  mtwg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_value_i (seed_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (out_valid),
    .out_word_o   (out_word)
  );

  assign req_i.ready       = req_ready;
  assign rsp_o.valid       = out_valid;
  assign rsp_o.random_word = out_word;

endmodule

// ----- rtl/mtwg_ram.sv -----
// ----------------------------------------------------------------------------
// mt word generator ram
// one write port, two registered read ports with read enables
// ----------------------------------------------------------------------------
module mtwg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_a_i,
  input  logic [$clog2(Depth)-1:0] addr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic                     re_b_i,
  input  logic [$clog2(Depth)-1:0] addr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_o <= mem_q[addr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[addr_b_i];
    end
  end

endmodule

// ----- rtl/mtwg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mt word generator controller
// sequences seeding, twisting and drawing of one word per request
// ----------------------------------------------------------------------------
module mtwg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_reseed_i,
  output logic              req_ready_o,
  input  mtwg_pkg::status_t status_i,
  output mtwg_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_WR,
    ST_SEED_ADD,
    ST_TW_START,
    ST_TW_LOAD,
    ST_TW_RD,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_reseed_i || !status_i.seeded) begin
            cmd_o.seed_start = 1'b1;
            state_d          = ST_SEED_WR;
          end else if (status_i.pos_full) begin
            cmd_o.tw_start = 1'b1;
            state_d        = ST_TW_LOAD;
          end else begin
            cmd_o.draw_read = 1'b1;
            state_d         = ST_DRAW_OUT;
          end
        end
      end
      ST_SEED_WR: begin
        cmd_o.seed_write = 1'b1;
        state_d          = status_i.k_last ? ST_TW_START : ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        cmd_o.seed_step = 1'b1;
        state_d         = ST_SEED_WR;
      end
      ST_TW_START: begin
        cmd_o.tw_start = 1'b1;
        state_d        = ST_TW_LOAD;
      end
      ST_TW_LOAD: begin
        cmd_o.tw_load = 1'b1;
        state_d       = ST_TW_RD;
      end
      ST_TW_RD: begin
        cmd_o.tw_read = 1'b1;
        state_d       = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd_o.tw_write = 1'b1;
        state_d        = status_i.k_last ? ST_DRAW_RD : ST_TW_RD;
      end
      ST_DRAW_RD: begin
        cmd_o.draw_read = 1'b1;
        state_d         = ST_DRAW_OUT;
      end
      ST_DRAW_OUT: begin
        // hold here until the output register can take the word
        if (status_i.out_free) begin
          cmd_o.draw_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/mtwg_datapath.sv -----
// ----------------------------------------------------------------------------
// mt word generator datapath
// seed register, state store, seeding and twist arithmetic, tempering
// ----------------------------------------------------------------------------
`include "mersenne_twister_word_generator_assert.svh"

module mtwg_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  seed_we_i,
  input  mtwg_pkg::word_t       seed_value_i,
  input  mtwg_pkg::cmd_t        cmd_i,
  output mtwg_pkg::status_t     status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output mtwg_pkg::word_t       out_word_o
);

  mtwg_pkg::word_t seed_q;
  mtwg_pkg::idx_t  k_q, k_d;
  mtwg_pkg::idx_t  pos_q, pos_d;
  logic            seeded_q, seeded_d;
  logic            out_valid_q, out_valid_d;
  mtwg_pkg::word_t out_word_q, out_word_d;
  mtwg_pkg::word_t prev_q, prev_d;
  mtwg_pkg::word_t prod_q, prod_d;
  mtwg_pkg::word_t cur_q, cur_d;

  logic            ram_we, ram_re_a, ram_re_b;
  mtwg_pkg::idx_t  ram_waddr, ram_addr_a, ram_addr_b;
  mtwg_pkg::word_t ram_wdata, ram_rdata_a, ram_rdata_b;

  mtwg_pkg::idx_t  k_inc, nxt_idx, mid_idx;
  mtwg_pkg::word_t mixed, twist_y, twist_v;
  logic            k_last;

  function automatic mtwg_pkg::word_t temper(input mtwg_pkg::word_t w);
    mtwg_pkg::word_t y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & mtwg_pkg::TEMPER_MASK_B);
    y = y ^ ((y << 15) & mtwg_pkg::TEMPER_MASK_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  assign k_last  = (k_q == mtwg_pkg::LAST_IDX);
  assign k_inc   = k_q + mtwg_pkg::idx_t'(1);
  assign nxt_idx = k_last ? '0 : k_inc;
  // middle word index wraps once k reaches the store length minus the offset
  assign mid_idx = (k_q < mtwg_pkg::WRAP_IDX) ? k_q + mtwg_pkg::MID_OFS
                                              : k_q - mtwg_pkg::WRAP_IDX;

  assign mixed   = prev_q ^ (prev_q >> 30);
  assign twist_y = (cur_q & mtwg_pkg::UPPER_MASK) | (ram_rdata_a & mtwg_pkg::LOWER_MASK);
  assign twist_v = ram_rdata_b ^ (twist_y >> 1)
                   ^ (twist_y[0] ? mtwg_pkg::TWIST_MATRIX : '0);

  assign status_o.seeded   = seeded_q;
  assign status_o.pos_full = (pos_q == mtwg_pkg::FULL_IDX);
  assign status_o.k_last   = k_last;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = k_q;
    ram_wdata   = prev_q;
    ram_re_a    = 1'b0;
    ram_addr_a  = pos_q;
    ram_re_b    = 1'b0;
    ram_addr_b  = mid_idx;
    k_d         = k_q;
    pos_d       = pos_q;
    seeded_d    = seeded_q;
    prev_d      = prev_q;
    prod_d      = prod_q;
    cur_d       = cur_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.seed_start) begin
      prev_d = seed_q;
      k_d    = '0;
    end
    if (cmd_i.seed_write) begin
      ram_we = 1'b1;
      prod_d = mixed * mtwg_pkg::SEED_MULT;
      if (k_last) begin
        pos_d    = mtwg_pkg::FULL_IDX;
        seeded_d = 1'b1;
      end
    end
    if (cmd_i.seed_step) begin
      prev_d = prod_q + mtwg_pkg::word_t'(k_inc);
      k_d    = k_inc;
    end
    if (cmd_i.tw_start) begin
      ram_re_a   = 1'b1;
      ram_addr_a = '0;
      k_d        = '0;
    end
    if (cmd_i.tw_load) begin
      cur_d = ram_rdata_a;
    end
    if (cmd_i.tw_read) begin
      ram_re_a   = 1'b1;
      ram_addr_a = nxt_idx;
      ram_re_b   = 1'b1;
    end
    if (cmd_i.tw_write) begin
      ram_we    = 1'b1;
      ram_wdata = twist_v;
      cur_d     = ram_rdata_a;
      k_d       = k_inc;
      if (k_last) begin
        pos_d = '0;
      end
    end
    if (cmd_i.draw_read) begin
      ram_re_a = 1'b1;
    end
    if (cmd_i.draw_out) begin
      out_word_d  = temper(ram_rdata_a);
      out_valid_d = 1'b1;
      pos_d       = pos_q + mtwg_pkg::idx_t'(1);
    end
  end

  mtwg_ram #(
    .Width(mtwg_pkg::WORD_W),
    .Depth(mtwg_pkg::STATE_WORDS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_a_i    (ram_re_a),
    .addr_a_i  (ram_addr_a),
    .rdata_a_o (ram_rdata_a),
    .re_b_i    (ram_re_b),
    .addr_b_i  (ram_addr_b),
    .rdata_b_o (ram_rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= mtwg_pkg::SEED_RESET;
      pos_q       <= mtwg_pkg::FULL_IDX;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_value_i;
      end
      pos_q       <= pos_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    prod_q     <= prod_d;
    cur_q      <= cur_d;
    out_word_q <= out_word_d;
  end

  `MTWG_ASSERT_NOW(a_draw_in_range, clk_i, rst_ni, cmd_i.draw_read, pos_q < mtwg_pkg::FULL_IDX, "draw read past end of store")
  `MTWG_ASSERT_NOW(a_out_no_overwrite, clk_i, rst_ni, cmd_i.draw_out, !out_valid_q || out_ready_i, "output word overwritten before transfer")
  `MTWG_ASSERT_NEXT(a_seed_done, clk_i, rst_ni, cmd_i.seed_write && k_last, seeded_q && pos_q == mtwg_pkg::FULL_IDX, "seeding did not leave store ready for twist")
  `MTWG_ASSERT_NEXT(a_twist_done, clk_i, rst_ni, cmd_i.tw_write && k_last, pos_q == '0, "twist did not restart read position")

endmodule
